// ===== sv/psr_pkg.sv =====
// Shared types, constants and helper functions for the pillbox sun ray direction block.
package psr_pkg;

    // Default fraction width of the input fractions and the sine register.
    localparam int FRAC_BITS_DEF = 24;

    // Internal fixed point: Q30 magnitudes up to one need 31 bits.
    localparam int ROOT_W   = 31;
    localparam int Q30_FRAC = 30;
    localparam int TRIG_W   = 32;
    localparam int CORD_W   = 34;
    localparam int ROT_STEPS = 28;

    // Result field widths and packing.
    localparam int DIR_XZ_W    = 24;
    localparam int DIR_Y_W     = 23;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_SHIFT   = 38;
    localparam int C22_SHIFT   = 8;

    localparam longint START_GAIN = 652032875;
    localparam longint ONE_Q30    = 64'd1 << 30;
    localparam longint ONE_Q60    = 64'd1 << 60;
    localparam longint ONE_Q22    = 64'd1 << 22;
    localparam longint OUT_ROUND  = 64'd1 << 37;
    localparam longint C22_ROUND  = 128;

    // Reset value of the cone sine, given at 24 fraction bits.
    localparam longint SUN_SINE_Q24 = 78018;
    localparam int     SUN_SINE_FRAC = 24;

    // Quarter-turn used to fold the phase into the CORDIC range.
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    // Arctangent of 2^-i in turns scaled by 2^32.
    function automatic logic signed [CORD_W-1:0] atan_turns(input int unsigned idx);
        logic signed [CORD_W-1:0] val;
        case (idx)
            0:  val = CORD_W'(536870912);
            1:  val = CORD_W'(316933406);
            2:  val = CORD_W'(167458907);
            3:  val = CORD_W'(85004757);
            4:  val = CORD_W'(42667331);
            5:  val = CORD_W'(21354465);
            6:  val = CORD_W'(10679838);
            7:  val = CORD_W'(5340245);
            8:  val = CORD_W'(2670163);
            9:  val = CORD_W'(1335087);
            10: val = CORD_W'(667544);
            11: val = CORD_W'(333772);
            12: val = CORD_W'(166886);
            13: val = CORD_W'(83443);
            14: val = CORD_W'(41722);
            15: val = CORD_W'(20861);
            16: val = CORD_W'(10430);
            17: val = CORD_W'(5215);
            18: val = CORD_W'(2608);
            19: val = CORD_W'(1304);
            20: val = CORD_W'(652);
            21: val = CORD_W'(326);
            22: val = CORD_W'(163);
            23: val = CORD_W'(81);
            24: val = CORD_W'(41);
            25: val = CORD_W'(20);
            26: val = CORD_W'(10);
            27: val = CORD_W'(5);
            default: val = '0;
        endcase
        return val;
    endfunction

    // Clamp a CORDIC value to plus or minus one in Q30.
    function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [CORD_W-1:0] v);
        logic signed [TRIG_W-1:0] res;
        if (v > CORD_W'(ONE_Q30)) begin
            res = TRIG_W'(ONE_Q30);
        end else if (v < -CORD_W'(ONE_Q30)) begin
            res = -TRIG_W'(ONE_Q30);
        end else begin
            res = v[TRIG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/psr_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module psr_sqrt #(
    parameter int ROOT_W = psr_pkg::ROOT_W,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);
    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]  rem_reg   [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
        localparam int B = ROOT_W - 1 - k;

        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [RAD_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in   = in_radicand;
            assign root_in  = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // Trial subtrahend is (2*root + bit) * bit for the current bit weight.
        assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
                side_reg[k] <= side_in;
            end
        end

        // The last stage has no use for the remainder.
        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== sv/psr_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of a phase in turns.
module psr_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  psr_pkg::quad_t                       in_quad,
    input  logic signed [31:0]                   in_angle,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic signed [psr_pkg::TRIG_W-1:0]    out_sin,
    output logic signed [psr_pkg::TRIG_W-1:0]    out_cos,
    output logic [SIDE_W-1:0]                    out_side
);
    localparam int W = psr_pkg::CORD_W;
    localparam int N = psr_pkg::ROT_STEPS;

    logic signed [W-1:0] x_reg     [N];
    logic signed [W-1:0] y_reg     [N];
    logic signed [W-1:0] z_reg     [N];
    psr_pkg::quad_t      quad_reg  [N];
    logic [SIDE_W-1:0]   side_reg  [N];
    logic                valid_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [W-1:0] x_in;
        logic signed [W-1:0] y_in;
        logic signed [W-1:0] z_in;
        psr_pkg::quad_t      quad_in;
        logic [SIDE_W-1:0]   side_in;
        logic                valid_in;
        logic signed [W-1:0] x_sh;
        logic signed [W-1:0] y_sh;

        if (i == 0) begin : g_first
            assign x_in     = W'(psr_pkg::START_GAIN);
            assign y_in     = '0;
            assign z_in     = W'(in_angle);
            assign quad_in  = in_quad;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_next
            assign x_in     = x_reg[i-1];
            assign y_in     = y_reg[i-1];
            assign z_in     = z_reg[i-1];
            assign quad_in  = quad_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign x_sh = x_in >>> i;
        assign y_sh = y_in >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end

        // Rotate toward zero residual angle.
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_in[W-1]) begin
                    x_reg[i] <= x_in - y_sh;
                    y_reg[i] <= y_in + x_sh;
                    z_reg[i] <= z_in - psr_pkg::atan_turns(i);
                end else begin
                    x_reg[i] <= x_in + y_sh;
                    y_reg[i] <= y_in - x_sh;
                    z_reg[i] <= z_in + psr_pkg::atan_turns(i);
                end
                quad_reg[i] <= quad_in;
                side_reg[i] <= side_in;
            end
        end
    end

    // Quadrant unfold and clamp.
    logic signed [W-1:0] cos_raw;
    logic signed [W-1:0] sin_raw;
    logic signed [psr_pkg::TRIG_W-1:0] sin_reg;
    logic signed [psr_pkg::TRIG_W-1:0] cos_reg;
    logic [SIDE_W-1:0] side_out_reg;
    logic              valid_out_reg;

    always_comb begin
        case (quad_reg[N-1])
            psr_pkg::QUAD_0: begin
                cos_raw = x_reg[N-1];
                sin_raw = y_reg[N-1];
            end
            psr_pkg::QUAD_90: begin
                cos_raw = -y_reg[N-1];
                sin_raw = x_reg[N-1];
            end
            psr_pkg::QUAD_180: begin
                cos_raw = -x_reg[N-1];
                sin_raw = -y_reg[N-1];
            end
            default: begin
                cos_raw = y_reg[N-1];
                sin_raw = -x_reg[N-1];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (en) begin
            valid_out_reg <= valid_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg      <= psr_pkg::clamp_q30(sin_raw);
            cos_reg      <= psr_pkg::clamp_q30(cos_raw);
            side_out_reg <= side_reg[N-1];
        end
    end

    assign out_valid = valid_out_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_side  = side_out_reg;

endmodule

// ===== sv/pillbox_sun_ray_direction.sv =====
// Top level of the pillbox sun ray direction generator.
//
//  channel   | ports                     | content (low bits first)
//  ----------+---------------------------+----------------------------------------
//  input     | s_axis_tvalid/tready/tdata| azimuth_fraction, radius_fraction
//  result    | m_axis_tvalid/tready/tdata| dir_x, dir_y, dir_z
//  config    | cfg_wr_en, cfg_wr_data    | sin_half_angle
//
// One transfer is accepted every cycle while the output is not stalled. Stages: input stage, 29 CORDIC
// stages, two 31-stage square roots (one bit each), four arithmetic stages, output stage.
// Reset clears all valid bits and loads the default cone sine.
// A stalled output freezes the whole pipeline in place; nothing is lost or repeated.
module pillbox_sun_ray_direction #(
    parameter int FRAC_BITS = psr_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [FRAC_BITS:0]                     cfg_wr_data,   // sin_half_angle
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // azimuth_fraction, radius_fraction, zero padding
    input  logic [((2*FRAC_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // dir_x [23:0], dir_y [46:24], dir_z [70:47], zero padding
    output logic [psr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    localparam int ROOT_W = psr_pkg::ROOT_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int TRIG_W = psr_pkg::TRIG_W;
    localparam int SCL_W  = FRAC_BITS + 31;
    localparam int XZ_W   = psr_pkg::DIR_XZ_W;
    localparam int Y_W    = psr_pkg::DIR_Y_W;
    localparam longint SHA_RESET =
        (psr_pkg::SUN_SINE_Q24 << FRAC_BITS) >> psr_pkg::SUN_SINE_FRAC;

    // Configuration register.
    logic [FRAC_BITS:0] sin_half_angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sin_half_angle_reg <= (FRAC_BITS+1)'(SHA_RESET);
        end else if (cfg_wr_en) begin
            sin_half_angle_reg <= cfg_wr_data;
        end
    end

    // Global advance: the pipeline moves whenever the output slot is free or taken.
    logic en;
    logic m_tvalid_reg;
    assign en            = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input stage: phase split and Q30 rescaling with saturation.
    logic [FRAC_BITS-1:0]  az;
    logic [FRAC_BITS-1:0]  rad;
    logic [FRAC_BITS+31:0] phase_wide;
    logic [31:0]           phase;
    logic [31:0]           phase_off;
    logic [SCL_W-1:0]      rad_wide;
    logic [SCL_W-1:0]      k_wide;
    logic [ROOT_W-1:0]     r30_next;
    logic [ROOT_W-1:0]     k30_next;

    assign az         = s_axis_tdata[FRAC_BITS-1:0];
    assign rad        = s_axis_tdata[2*FRAC_BITS-1:FRAC_BITS];
    assign phase_wide = {az, 32'd0} >> FRAC_BITS;
    assign phase      = phase_wide[31:0];
    assign phase_off  = phase + 32'h2000_0000;
    assign rad_wide   = {1'b0, rad, 30'd0} >> FRAC_BITS;
    assign k_wide     = {sin_half_angle_reg, 30'd0} >> FRAC_BITS;
    assign r30_next   = (rad_wide > SCL_W'(psr_pkg::ONE_Q30)) ?
                        ROOT_W'(psr_pkg::ONE_Q30) : rad_wide[ROOT_W-1:0];
    assign k30_next   = (k_wide > SCL_W'(psr_pkg::ONE_Q30)) ?
                        ROOT_W'(psr_pkg::ONE_Q30) : k_wide[ROOT_W-1:0];

    logic                v0_reg;
    psr_pkg::quad_t      quad0_reg;
    logic signed [31:0]  angle0_reg;
    logic [ROOT_W-1:0]   r30_0_reg;
    logic [ROOT_W-1:0]   k30_0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad0_reg  <= psr_pkg::quad_t'(phase_off[31:30]);
            angle0_reg <= signed'(phase - {phase_off[31:30], 30'd0});
            r30_0_reg  <= r30_next;
            k30_0_reg  <= k30_next;
        end
    end

    // Sine and cosine of the azimuth.
    logic                     v1;
    logic signed [TRIG_W-1:0] sn1;
    logic signed [TRIG_W-1:0] cs1;
    logic [2*ROOT_W-1:0]      side1;

    psr_cordic #(
        .SIDE_W (2*ROOT_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_quad   (quad0_reg),
        .in_angle  (angle0_reg),
        .in_side   ({k30_0_reg, r30_0_reg}),
        .out_valid (v1),
        .out_sin   (sn1),
        .out_cos   (cs1),
        .out_side  (side1)
    );

    // Square root of the radius fraction.
    localparam int SIDE_S_W = ROOT_W + 2*TRIG_W;

    logic                v2;
    logic [ROOT_W-1:0]   root2;
    logic [SIDE_S_W-1:0] side2;

    psr_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SIDE_S_W)
    ) u_sqrt_radius (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v1),
        .in_radicand ({1'b0, side1[ROOT_W-1:0], 30'd0}),
        .in_side     ({side1[2*ROOT_W-1:ROOT_W], sn1, cs1}),
        .out_valid   (v2),
        .out_root    (root2),
        .out_side    (side2)
    );

    // Polar sine: cone sine times root, clamped to one.
    logic [RAD_W-1:0]         s_prod;
    logic [31:0]              s_hi;
    logic                     v3_reg;
    logic [ROOT_W-1:0]        s30_3_reg;
    logic signed [TRIG_W-1:0] sn3_reg;
    logic signed [TRIG_W-1:0] cs3_reg;

    assign s_prod = RAD_W'(side2[SIDE_S_W-1:2*TRIG_W]) * RAD_W'(root2);
    assign s_hi   = s_prod[RAD_W-1:psr_pkg::Q30_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s30_3_reg <= (s_hi > 32'(psr_pkg::ONE_Q30)) ?
                         ROOT_W'(psr_pkg::ONE_Q30) : s_hi[ROOT_W-1:0];
            sn3_reg   <= side2[2*TRIG_W-1:TRIG_W];
            cs3_reg   <= side2[TRIG_W-1:0];
        end
    end

    // Square of the polar sine.
    logic                     v4_reg;
    logic [RAD_W-1:0]         sq4_reg;
    logic [ROOT_W-1:0]        s30_4_reg;
    logic signed [TRIG_W-1:0] sn4_reg;
    logic signed [TRIG_W-1:0] cs4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq4_reg   <= RAD_W'(s30_3_reg) * RAD_W'(s30_3_reg);
            s30_4_reg <= s30_3_reg;
            sn4_reg   <= sn3_reg;
            cs4_reg   <= cs3_reg;
        end
    end

    // One minus the square, feeding the cosine root.
    logic                     v5_reg;
    logic [RAD_W-1:0]         diff5_reg;
    logic [ROOT_W-1:0]        s30_5_reg;
    logic signed [TRIG_W-1:0] sn5_reg;
    logic signed [TRIG_W-1:0] cs5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff5_reg <= RAD_W'(psr_pkg::ONE_Q60) - sq4_reg;
            s30_5_reg <= s30_4_reg;
            sn5_reg   <= sn4_reg;
            cs5_reg   <= cs4_reg;
        end
    end

    logic                v6;
    logic [ROOT_W-1:0]   c30_6;
    logic [SIDE_S_W-1:0] side6;

    psr_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SIDE_S_W)
    ) u_sqrt_cos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v5_reg),
        .in_radicand (diff5_reg),
        .in_side     ({s30_5_reg, sn5_reg, cs5_reg}),
        .out_valid   (v6),
        .out_root    (c30_6),
        .out_side    (side6)
    );

    // Output products and rounded polar cosine.
    logic signed [31:0] s_sig;
    logic [31:0]        c_round;
    logic [23:0]        c_shift;
    logic               v7_reg;
    logic signed [63:0] px7_reg;
    logic signed [63:0] pz7_reg;
    logic [Y_W-1:0]     c22_7_reg;

    assign s_sig   = signed'(32'(side6[SIDE_S_W-1:2*TRIG_W]));
    assign c_round = 32'(c30_6) + 32'(psr_pkg::C22_ROUND);
    assign c_shift = c_round[psr_pkg::C22_SHIFT+23:psr_pkg::C22_SHIFT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px7_reg   <= 64'(s_sig) * 64'(signed'(side6[2*TRIG_W-1:TRIG_W]));
            pz7_reg   <= 64'(s_sig) * 64'(signed'(side6[TRIG_W-1:0]));
            c22_7_reg <= (c_shift > 24'(psr_pkg::ONE_Q22)) ?
                         Y_W'(psr_pkg::ONE_Q22) : c_shift[Y_W-1:0];
        end
    end

    // Final rounding, clamping and packing.
    logic signed [63:0]   px_sh;
    logic signed [63:0]   pz_sh;
    logic signed [XZ_W-1:0] dir_x;
    logic signed [XZ_W-1:0] dir_z;
    logic [Y_W-1:0]       dir_y;
    logic [psr_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    assign px_sh = (px7_reg + 64'(psr_pkg::OUT_ROUND)) >>> psr_pkg::OUT_SHIFT;
    assign pz_sh = (pz7_reg + 64'(psr_pkg::OUT_ROUND)) >>> psr_pkg::OUT_SHIFT;

    always_comb begin
        if (px_sh > 64'(psr_pkg::ONE_Q22)) begin
            dir_x = XZ_W'(psr_pkg::ONE_Q22);
        end else if (px_sh < -64'(psr_pkg::ONE_Q22)) begin
            dir_x = -XZ_W'(psr_pkg::ONE_Q22);
        end else begin
            dir_x = px_sh[XZ_W-1:0];
        end
        if (pz_sh > 64'(psr_pkg::ONE_Q22)) begin
            dir_z = XZ_W'(psr_pkg::ONE_Q22);
        end else if (pz_sh < -64'(psr_pkg::ONE_Q22)) begin
            dir_z = -XZ_W'(psr_pkg::ONE_Q22);
        end else begin
            dir_z = pz_sh[XZ_W-1:0];
        end
        dir_y = ~c22_7_reg + Y_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {1'b0, dir_z, dir_y, dir_x};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // The y component is never positive.
    a_dir_y_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[46:24] == '0 || m_axis_tdata[46]))
        else $error("dir_y positive");

    // The x component stays within plus or minus one.
    a_dir_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[23:0]) <= 24'sd4194304 &&
                           $signed(m_axis_tdata[23:0]) >= -24'sd4194304))
        else $error("dir_x out of range");

    // The polar sine never exceeds one.
    a_sine_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (s30_3_reg <= ROOT_W'(psr_pkg::ONE_Q30)))
        else $error("polar sine above one");

    // A stall freezes the stage ahead of the output register.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v7_reg) && $stable(px7_reg)))
        else $error("pipeline moved during stall");

endmodule

// ===== test/psr_checker.sv =====
// Checker for the pillbox sun ray direction block: predicts each result and compares it.
module psr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [24:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic signed [23:0] dir_z;
        logic signed [22:0] dir_y;
        logic signed [23:0] dir_x;
    } ray_dir_t;

    localparam longint ARCTAN_TURNS [28] = '{
        536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };
    localparam longint UNIT_Q30 = 64'sd1 << 30;
    localparam longint UNIT_Q22 = 64'sd1 << 22;

    logic [24:0] cone_sine;
    ray_dir_t    expected_dirs[$];

    // Integer square root rounded down.
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned frac_to_q30(input longint unsigned v);
        longint unsigned t;
        t = (v << 30) >> 24;
        return (t > UNIT_Q30) ? UNIT_Q30 : t;
    endfunction

    // Computes the direction for one pair of fractions under the current cone sine.
    function automatic ray_dir_t predict_direction(input logic [23:0] az,
                                                   input logic [23:0] rad);
        logic [31:0]     phase;
        logic [1:0]      quad;
        logic [31:0]     resid;
        longint          x, y, z, nx, sn, cs, sx, sz;
        longint unsigned s30, c22, root30;
        ray_dir_t        d;
        phase  = {az, 8'd0};
        quad   = 2'((phase + 32'h2000_0000) >> 30);
        resid  = phase - {quad, 30'd0};
        z      = longint'(signed'(resid));
        x      = 652032875;
        y      = 0;
        for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN_TURNS[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN_TURNS[i];
            end
            x = nx;
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        cs = clamp(cs, UNIT_Q30);
        sn = clamp(sn, UNIT_Q30);
        root30 = isqrt(frac_to_q30(rad) << 30);
        s30    = (frac_to_q30(cone_sine) * root30) >> 30;
        if (s30 > UNIT_Q30) s30 = UNIT_Q30;
        c22 = (isqrt((64'd1 << 60) - s30 * s30) + 128) >> 8;
        if (c22 > UNIT_Q22) c22 = UNIT_Q22;
        sx = clamp((longint'(s30) * sn + (64'sd1 << 37)) >>> 38, UNIT_Q22);
        sz = clamp((longint'(s30) * cs + (64'sd1 << 37)) >>> 38, UNIT_Q22);
        d.dir_x = 24'(sx);
        d.dir_y = 23'(-longint'(c22));
        d.dir_z = 24'(sz);
        return d;
    endfunction

    assign pending_count = expected_dirs.size();

    // Register writes, input transfers and result checks all happen on the rising edge.
    always @(posedge aclk) begin
        ray_dir_t got, want;
        if (!aresetn) begin
            cone_sine = 25'd78018;
            expected_dirs.delete();
            error_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[70:0];
                if (expected_dirs.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_dirs.pop_front();
                    if (got.dir_x !== want.dir_x) begin
                        $display("%0t: dir_x expected %0d got %0d", $time, want.dir_x,
                                 got.dir_x);
                        error_count++;
                    end
                    if (got.dir_y !== want.dir_y) begin
                        $display("%0t: dir_y expected %0d got %0d", $time, want.dir_y,
                                 got.dir_y);
                        error_count++;
                    end
                    if (got.dir_z !== want.dir_z) begin
                        $display("%0t: dir_z expected %0d got %0d", $time, want.dir_z,
                                 got.dir_z);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_dirs.push_back(predict_direction(s_axis_tdata[23:0],
                                                          s_axis_tdata[47:24]));
            if (cfg_wr_en) cone_sine = cfg_wr_data;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Stimulus and verdict for the pillbox sun ray direction block.
module testbench;

    localparam int PIPE_LATENCY = 97;
    localparam int STALL_LIMIT  = 5000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [24:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    int          error_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          idle_cycles;

    pillbox_sun_ray_direction uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    psr_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .error_count(error_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one item and waits for its transfer. The valid stays high on return,
    // so the caller either offers the next item or drops it at the same falling edge.
    task automatic send_fractions(input logic [23:0] az, input logic [23:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rad, az};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Waits until every result is back and the pipeline has emptied.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_cone_sine(input logic [24:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random fraction biased toward the ends of the range and the quarter points.
    function automatic logic [23:0] rand_fraction;
        case ($urandom_range(7))
            0: return 24'hFFFFFF - 24'($urandom_range(3));
            1: return 24'($urandom_range(3));
            2: return 24'($urandom_range(3)) << 22;
            default: return 24'($urandom);
        endcase
    endfunction

    logic [24:0] sine_set [6] = '{25'd78018, 25'd0, 25'd16777216, 25'h1FFFFFF,
                                  25'd8388608, 25'd1000000};

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: default cone, field extremes and quadrant boundaries.
        send_fractions(24'd0, 24'd0);
        send_fractions(24'hFFFFFF, 24'hFFFFFF);
        send_fractions(24'h400000, 24'hFFFFFF);
        send_fractions(24'h800000, 24'h800000);
        send_fractions(24'hC00000, 24'hFFFFFF);
        send_fractions(24'h200000, 24'h000001);
        send_fractions(24'h555555, 24'hAAAAAA);
        send_fractions(24'hAAAAAA, 24'h555555);
        drain();
        // Full cone and a register value above one, which saturates.
        write_cone_sine(25'd16777216);
        for (int q = 0; q < 4; q++) send_fractions(24'(q) << 22, 24'hFFFFFF);
        drain();
        write_cone_sine(25'h1FFFFFF);
        send_fractions(24'h123456, 24'hFFFFFF);
        send_fractions(24'h600000, 24'hFFFFFF);
        drain();

        // Random phases with several idling patterns and cone settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_cone_sine(sine_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < 250; n++) begin
                send_fractions(rand_fraction(), rand_fraction());
            end
            drain();
        end

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 150; n++) send_fractions(rand_fraction(), rand_fraction());
        join
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
